[sv/utcgw_pkg.sv]
// Package with the widths, reciprocal constants and calendar helpers of the UTC to GPS week converter.
package utcgw_pkg;

	localparam int DATE_W = 19;
	localparam int TIME_W = 28;
	localparam int WEEK_W = 13;
	localparam int MS_W   = 30;
	localparam int LEAP_W = 8;

	// Reciprocals for division by constants: q = (x * M) >> SH, exact over the value ranges used.
	localparam logic [18:0] M_DIV10K  = 19'd429497;
	localparam int          SH_DIV10K = 32;
	localparam logic [28:0] M_DIV1K   = 29'd274877907;
	localparam int          SH_DIV1K  = 38;
	localparam logic [13:0] M_DIV100  = 14'd10486;
	localparam int          SH_DIV100 = 20;
	localparam logic [16:0] M_DIV7    = 17'd74899;
	localparam int          SH_DIV7   = 19;

	localparam logic [LEAP_W-1:0] LEAP_RESET = 8'd18;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [19:0] SECS_PER_WEEK = 20'd604800;

	// Day number of the GPS epoch counted from 1970, plus one for the day-of-month offset.
	localparam logic [15:0] EPOCH_DAY_PLUS1 = 16'd3658;

	// Year 2100 and year 2101 relative to 1968.
	localparam logic [7:0] YO_2100 = 8'd132;
	localparam logic [7:0] YO_2101 = 8'd133;

	function automatic logic [8:0] days_before_month(input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[sv/utc_date_time_to_gps_week_top.sv]
// Pipelined converter from a ddmmyy date and hhmmss.mmm time to GPS week and millisecond of week.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------
//   command  | in        | start, busy           | date_code[18:0], time_code[27:0]
//   result   | out       | done (strobe)         | gps_week[12:0], week_millis[29:0]
//   config   | in        | cfg_valid, cfg_ready  | cfg_data[7:0] (leap seconds)
//
// Each transfer on the command channel gives one result, marked by done.
// A new command is taken in every cycle; busy stays low because the pipeline never stalls.
// The latency is set by ten register stages; the six reciprocal products fill four of them.
// Reset clears the stage valid bits and loads 18 leap seconds; cfg_ready is always high.
module utc_date_time_to_gps_week_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [utcgw_pkg::DATE_W-1:0]  date_code,
	input  logic [utcgw_pkg::TIME_W-1:0]  time_code,
	output logic                          done,
	output logic [utcgw_pkg::WEEK_W-1:0]  gps_week,
	output logic [utcgw_pkg::MS_W-1:0]    week_millis,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [utcgw_pkg::LEAP_W-1:0]  cfg_data
);
	import utcgw_pkg::*;

	logic [LEAP_W-1:0] leap_q;
	logic [10:1] v_s;

	logic [DATE_W-1:0] date_s1;
	logic [TIME_W-1:0] tcode_s1;
	logic [37:0] pd_s1;
	logic [56:0] pt_s1;

	logic [5:0]  dd_s2, dd_s3, dd_s4, dd_s5;
	logic [13:0] rd_s2, rd_s3;
	logic [18:0] tsec_s2, tsec_s3;
	logic [9:0]  ms_s2, ms_s3, ms_s4, ms_s5, ms_s6, ms_s7, ms_s8, ms_s9;

	logic [27:0] mmp_s3;
	logic [37:0] hp_s3;

	logic [6:0]  mm_s4, yy_s4;
	logic [4:0]  hour_s4, hour_s5;
	logic [13:0] r2_s4, r2_s5;

	logic [27:0] minp_s5;
	logic [6:0]  yidx_s5;
	logic [3:0]  mon_s5;

	logic [16:0] tod_s6, tod_s7;
	logic [15:0] gday_s6, gday_s7;
	logic [32:0] wp_s7;

	logic [12:0] wk_s8, wk_s9;
	logic [19:0] wsec_s8, wsec_s9;

	// Stage two combinational values.
	logic [5:0]  dd_c;
	logic [18:0] tsec_c;
	logic [18:0] rd_full;
	logic [27:0] ms_full;

	// Stage four.
	logic [6:0]  mm_c, yy_c;
	logic [4:0]  hour_c;
	logic [13:0] yy_full;
	logic [18:0] r2_full;

	// Stage five.
	logic [6:0]  m1_c;
	logic [12:0] q_prod;
	logic [3:0]  q_c;
	logic [6:0]  mon_full;

	// Stage six.
	logic [6:0]  min_c;
	logic [13:0] sec_full;
	logic [7:0]  yo_c;
	logic [15:0] days1970_c;
	logic        leap_year_c;
	logic [15:0] gday_c;

	// Stage eight.
	logic [12:0] wk_c;
	logic [15:0] dow_full;
	logic [19:0] wsec_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = v_s[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leap_q <= LEAP_RESET;
			v_s    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				leap_q <= cfg_data;
			end
			v_s <= {v_s[9:1], start && !busy};
		end
	end

	always_comb begin
		dd_c    = pd_s1[SH_DIV10K +: 6];
		rd_full = date_s1 - 19'(dd_c * 14'd10000);
		tsec_c  = pt_s1[SH_DIV1K +: 19];
		ms_full = tcode_s1 - 28'(tsec_c * 10'd1000);

		mm_c    = mmp_s3[SH_DIV100 +: 7];
		yy_full = rd_s3 - 14'(mm_c * 7'd100);
		yy_c    = yy_full[6:0];
		hour_c  = hp_s3[SH_DIV10K +: 5];
		r2_full = tsec_s3 - 19'(hour_c * 14'd10000);

		m1_c     = mm_s4 - 7'd1;
		q_prod   = m1_c * 6'd43;
		q_c      = q_prod[12:9];
		mon_full = m1_c - 7'(q_c * 4'd12);

		min_c       = minp_s5[SH_DIV100 +: 7];
		sec_full    = r2_s5 - 14'(min_c * 7'd100);
		yo_c        = {1'b0, yidx_s5} + 8'd31;
		days1970_c  = 16'(yo_c - 8'd2) * 16'd365 + 16'((9'(yo_c) + 9'd3) >> 2) - 16'd1
			- ((yo_c >= YO_2101) ? 16'd1 : 16'd0);
		leap_year_c = (yo_c[1:0] == 2'd0) && (yo_c != YO_2100);
		gday_c      = days1970_c + 16'(days_before_month(mon_s5))
			+ ((mon_s5 > 4'd1 && leap_year_c) ? 16'd1 : 16'd0)
			+ 16'(dd_s5) - EPOCH_DAY_PLUS1;

		wk_c     = wp_s7[SH_DIV7 +: 13];
		dow_full = gday_s7 - 16'(wk_c * 3'd7);
		wsec_c   = 20'(dow_full[2:0] * SECS_PER_DAY) + 20'(tod_s7) + 20'(leap_q);
	end

	always_ff @(posedge clk) begin
		date_s1  <= date_code;
		tcode_s1 <= time_code;
		pd_s1    <= 38'(date_code) * 38'(M_DIV10K);
		pt_s1    <= 57'(time_code) * 57'(M_DIV1K);

		dd_s2   <= dd_c;
		rd_s2   <= rd_full[13:0];
		tsec_s2 <= tsec_c;
		ms_s2   <= ms_full[9:0];

		mmp_s3  <= 28'(rd_s2) * 28'(M_DIV100);
		hp_s3   <= 38'(tsec_s2) * 38'(M_DIV10K);
		rd_s3   <= rd_s2;
		tsec_s3 <= tsec_s2;
		dd_s3   <= dd_s2;
		ms_s3   <= ms_s2;

		mm_s4   <= mm_c;
		yy_s4   <= yy_c;
		hour_s4 <= hour_c;
		r2_s4   <= r2_full[13:0];
		dd_s4   <= dd_s3;
		ms_s4   <= ms_s3;

		minp_s5 <= 28'(r2_s4) * 28'(M_DIV100);
		r2_s5   <= r2_s4;
		hour_s5 <= hour_s4;
		if (mm_s4 == 7'd0) begin
			yidx_s5 <= yy_s4;
			mon_s5  <= 4'd11;
		end else begin
			yidx_s5 <= yy_s4 + 7'd1 + 7'(q_c);
			mon_s5  <= mon_full[3:0];
		end
		dd_s5 <= dd_s4;
		ms_s5 <= ms_s4;

		tod_s6  <= 17'(hour_s5 * 12'd3600) + 17'(min_c * 6'd60) + 17'(sec_full[6:0]);
		gday_s6 <= gday_c;
		ms_s6   <= ms_s5;

		wp_s7   <= 33'(gday_s6) * 33'(M_DIV7);
		gday_s7 <= gday_s6;
		tod_s7  <= tod_s6;
		ms_s7   <= ms_s6;

		wk_s8   <= wk_c;
		wsec_s8 <= wsec_c;
		ms_s8   <= ms_s7;

		if (wsec_s8 >= SECS_PER_WEEK) begin
			wsec_s9 <= wsec_s8 - SECS_PER_WEEK;
			wk_s9   <= wk_s8 + 13'd1;
		end else begin
			wsec_s9 <= wsec_s8;
			wk_s9   <= wk_s8;
		end
		ms_s9 <= ms_s8;

		gps_week    <= wk_s9;
		week_millis <= 30'(wsec_s9) * 30'd1000 + 30'(ms_s9);
	end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the UTC date and time to GPS week converter.
`timescale 1ns / 100ps

module tb_top;
	import utcgw_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam logic [63:0] GPS_EPOCH_SECS = 64'd315964800;
	localparam logic [63:0] DAY_SECS = 64'd86400;
	localparam logic [63:0] WEEK_SECS = 64'd604800;

	typedef struct packed {
		logic [DATE_W-1:0] date;
		logic [TIME_W-1:0] tod;
	} utc_cmd_t;

	typedef struct packed {
		logic [WEEK_W-1:0] week;
		logic [MS_W-1:0]   wms;
	} gps_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [DATE_W-1:0] date_code = '0;
	logic [TIME_W-1:0] time_code = '0;
	logic              done;
	logic [WEEK_W-1:0] gps_week;
	logic [MS_W-1:0]   week_millis;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEAP_W-1:0] cfg_data = '0;

	utc_cmd_t    utc_cmd_q[$];
	gps_res_t    gps_due_q[$];
	utc_cmd_t    next_cmd;
	gps_res_t    due;
	logic [7:0]  leap_now = LEAP_RESET;
	logic [7:0]  leap_mid;
	int unsigned idle_pct = 20;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_err = 0;
	int unsigned cycles = 0;

	utc_date_time_to_gps_week_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.date_code   (date_code),
		.time_code   (time_code),
		.done        (done),
		.gps_week    (gps_week),
		.week_millis (week_millis),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] leaps_upto(input logic [63:0] y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic gps_res_t utc_to_gps(input logic [DATE_W-1:0] date,
			input logic [TIME_W-1:0] tod, input logic [7:0] leap);
		logic [63:0] d, t, yy, mon_code, dd, ms, ss, mi, hh, yr, mon, cum, days, secs, gsec, q;
		gps_res_t r;
		d = 64'(date);
		t = 64'(tod);
		yy = d % 100;
		mon_code = (d / 100) % 100;
		dd = d / 10000;
		ms = t % 1000;
		ss = (t / 1000) % 100;
		mi = (t / 100000) % 100;
		hh = (t / 10000000) % 100;
		// Month zero falls back to December of the year before.
		if (mon_code == 0) begin
			yr = 1999 + yy;
			mon = 11;
		end else begin
			yr = 2000 + yy + (mon_code - 1) / 12;
			mon = (mon_code - 1) % 12;
		end
		case (mon)
			0:  cum = 0;
			1:  cum = 31;
			2:  cum = 59;
			3:  cum = 90;
			4:  cum = 120;
			5:  cum = 151;
			6:  cum = 181;
			7:  cum = 212;
			8:  cum = 243;
			9:  cum = 273;
			10: cum = 304;
			default: cum = 334;
		endcase
		days = 365 * (yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969) + cum;
		if (mon > 1 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)) begin
			days = days + 1;
		end
		// Day zero is the last day of the previous month; the sum stays positive.
		secs = days * DAY_SECS + hh * 3600 + mi * 60 + ss + dd * DAY_SECS - DAY_SECS;
		gsec = secs + 64'(leap) - GPS_EPOCH_SECS;
		q = gsec / WEEK_SECS;
		r.week = q[WEEK_W-1:0];
		q = (gsec % WEEK_SECS) * 1000 + ms;
		r.wms = q[MS_W-1:0];
		return r;
	endfunction

	task automatic push_cmd(input int unsigned d, input int unsigned t);
		utc_cmd_t c;
		c.date = d[DATE_W-1:0];
		c.tod = t[TIME_W-1:0];
		utc_cmd_q.push_back(c);
	endtask

	task automatic push_random_cmd();
		int unsigned sel, d, t;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			d = $urandom_range(1, 31) * 10000 + $urandom_range(1, 12) * 100
				+ $urandom_range(0, 99);
			t = ($urandom_range(0, 23) * 10000 + $urandom_range(0, 59) * 100
				+ $urandom_range(0, 59)) * 1000 + $urandom_range(0, 999);
		end else if (sel == 7) begin
			d = $urandom_range(0, 31) * 10000 + $urandom_range(0, 99) * 100
				+ $urandom_range(0, 99);
			t = ($urandom_range(0, 23) * 10000 + $urandom_range(0, 99) * 100
				+ $urandom_range(0, 99)) * 1000 + $urandom_range(0, 999);
			if (d > 311299) d = $urandom_range(0, 311299);
			if (t > 235959999) t = $urandom_range(0, 235959999);
		end else begin
			d = $urandom_range(0, 311299);
			t = $urandom_range(0, 235959999);
		end
		push_cmd(d, t);
	endtask

	task automatic write_leap(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		leap_now = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (utc_cmd_q.size() != 0 || start || gps_due_q.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic run_random_phase(input int unsigned pct, input int unsigned count);
		@(negedge clk);
		idle_pct = pct;
		push_cmd(311299, 235959999);
		push_cmd(0, 0);
		repeat (count) push_random_cmd();
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				gps_due_q.push_back(utc_to_gps(date_code, time_code, leap_now));
				n_sent++;
			end
			if (!(start && busy)) begin
				if (utc_cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					next_cmd = utc_cmd_q.pop_front();
					start <= 1'b1;
					date_code <= next_cmd.date;
					time_code <= next_cmd.tod;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (gps_due_q.size() == 0) begin
				if (n_err < 10) begin
					$display("Unexpected result: week %0d millis %0d", gps_week, week_millis);
				end
				n_err++;
			end else begin
				due = gps_due_q.pop_front();
				n_checked++;
				if (gps_week !== due.week || week_millis !== due.wms) begin
					if (n_err < 10) begin
						$display("Mismatch on result %0d: week exp %0d got %0d, millis exp %0d got %0d",
							n_checked, due.week, gps_week, due.wms, week_millis);
					end
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout with %0d results outstanding.", gps_due_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 20;
		push_cmd(0, 0);
		push_cmd(10100, 0);
		push_cmd(10100, 235959999);
		push_cmd(311299, 235959999);
		push_cmd(290200, 120000000);
		push_cmd(10300, 0);
		push_cmd(290296, 60000500);
		push_cmd(10397, 0);
		push_cmd(150023, 101010010);
		push_cmd(11399, 0);
		push_cmd(11599, 0);
		push_cmd(19999, 999);
		push_cmd(324, 0);
		push_cmd(310224, 235959999);
		push_cmd(10124, 9999999);
		push_cmd(10124, 199999999);
		push_cmd(262143, 134217727);
		push_cmd(50119, 235941999);
		push_cmd(50119, 235942000);
		push_cmd(60119, 999);
		wait_drained();

		write_leap(8'd0);
		run_random_phase(20, 200);
		write_leap(8'd255);
		run_random_phase(58, 200);
		leap_mid = 8'($urandom_range(1, 254));
		write_leap(leap_mid);
		run_random_phase(0, 200);

		repeat (8) @(negedge clk);
		$display("Sent %0d conversions and checked %0d results with leap offsets 18, 0, 255, %0d,",
			n_sent, n_checked, leap_mid);
		$display("covering calendar edge cases, out-of-range fields and idle gaps of 0, 20 and 58 percent.");
		if (n_err == 0 && gps_due_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
